// File: rtl/core/eft_pkg.sv
// Shared codes, field widths and constants for the event flag table.
package eft_pkg;

	localparam int FUNC_W     = 2;
	localparam int ID_W       = 8;
	localparam int PAT_W      = 32;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int MAX_WORD_W = 64;

	localparam int FIU_W      = 5;
	localparam int MASK_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [FUNC_W-1:0] FN_SET   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FN_WAIT  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ALL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ANY = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_PAR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_MET = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FLAGS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_MASK   = 1'd1;

	localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

endpackage

// File: rtl/core/eft_if.sv
// Operation and result channel interfaces of the event flag table.
interface eft_op_if import eft_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   flag_id;
	logic [PAT_W-1:0]  pattern;
	logic [MODE_W-1:0] wait_mode;

	modport source (output valid, func, flag_id, pattern, wait_mode, input ready);
	modport sink   (input valid, func, flag_id, pattern, wait_mode, output ready);
endinterface

interface eft_res_if import eft_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PAT_W-1:0]    flag_pattern;

	modport source (output valid, status, flag_pattern, input ready);
	modport sink   (input valid, status, flag_pattern, output ready);
endinterface

// File: rtl/core/eft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module eft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents when both ports hit the same entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/event_flag_table.sv
// Event flag table: set / clear / polling wait on a RAM of flag words.
//
//   channel  dir  transfer when     payload
//   op       in   valid & ready     func, flag_id, pattern, wait_mode
//   res      out  valid & ready     status, flag_pattern
//   cfg      in   cfg_we            cfg_index, cfg_wdata
//
// The result is registered after the modify stage; one op per cycle sustained while res is not stalled.
// The op transfer issues the flag RAM read; the modify stage modifies the word and writes it back;
// the last write is forwarded to cover a read of the same entry.
// Reset clears per-entry valid bits at once; an unwritten word reads zero.
// A stalled result holds the modify stage, which then holds the op channel.
module event_flag_table import eft_pkg::*; #(
	parameter int NUM_FLAGS    = 16,
	parameter int PATTERN_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	eft_op_if.sink                op,
	eft_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;

	logic [FIU_W-1:0]  fiu_q;
	logic [MASK_W-1:0] clr_mask_q;

	logic                    s1_valid;
	logic [FUNC_W-1:0]       s1_func;
	logic [ID_W-1:0]         s1_id;
	logic [PATTERN_BITS-1:0] s1_pat;
	logic [MODE_W-1:0]       s1_mode;

	logic                    fwd_valid_q;
	logic [AW-1:0]           fwd_addr_q;
	logic [PATTERN_BITS-1:0] fwd_data_q;

	logic [NUM_FLAGS-1:0]    valid_q;

	logic                    res_valid_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [PAT_W-1:0]        res_pat_q;

	logic                    op_xfer;
	logic                    s1_adv;
	logic [MAX_WORD_W-1:0]   pat_wide;
	logic [PATTERN_BITS-1:0] pat_in;
	logic [AW-1:0]           s1_addr;
	logic [PATTERN_BITS-1:0] rd_data;
	logic [PATTERN_BITS-1:0] word;
	logic                    id_ok;
	logic                    auto_clr;
	logic                    met;
	logic [STATUS_W-1:0]     status;
	logic [PATTERN_BITS-1:0] seen;
	logic [MAX_WORD_W-1:0]   seen_wide;
	logic                    wr_en;
	logic [PATTERN_BITS-1:0] wr_data;

	assign op_xfer  = op.valid && op.ready;
	assign s1_adv   = s1_valid && (!res_valid_q || res.ready);
	assign op.ready = !s1_valid || s1_adv;

	assign pat_wide = MAX_WORD_W'(op.pattern);
	assign pat_in   = pat_wide[PATTERN_BITS-1:0];
	assign s1_addr  = s1_id[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q      <= FIU_RESET;
			clr_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLAGS_IN_USE: fiu_q      <= cfg_wdata[FIU_W-1:0];
				CFG_CLEAR_MASK:   clr_mask_q <= cfg_wdata[MASK_W-1:0];
				default:          ;
			endcase
		end
	end

	eft_ram #(
		.WIDTH (PATTERN_BITS),
		.DEPTH (NUM_FLAGS)
	) u_words (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s1_addr),
		.wdata (wr_data),
		.re    (op_xfer),
		.raddr (op.flag_id[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (op.ready) begin
			s1_valid <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_xfer) begin
			s1_func <= op.func;
			s1_id   <= op.flag_id;
			s1_pat  <= pat_in;
			s1_mode <= op.wait_mode;
		end
	end

	// newest word: last write-back, else RAM, else zero if never written
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == s1_addr) begin
			word = fwd_data_q;
		end else if (valid_q[s1_addr]) begin
			word = rd_data;
		end else begin
			word = '0;
		end
	end

	assign id_ok = ({1'b0, s1_id} < (ID_W + 1)'(NUM_FLAGS)) &&
		(s1_id < ID_W'(fiu_q));
	assign auto_clr = (s1_id < ID_W'(MASK_W)) && clr_mask_q[s1_id[3:0]];
	assign met = (s1_mode == MODE_ANY) ? ((word & s1_pat) != '0)
		: ((word & s1_pat) == s1_pat);

	always_comb begin
		status  = ST_OK;
		seen    = '0;
		wr_en   = 1'b0;
		wr_data = '0;
		priority if (!id_ok) begin
			status = ST_BAD_ID;
		end else if (s1_func == FN_SET) begin
			wr_en   = s1_adv;
			wr_data = word | s1_pat;
		end else if (s1_func == FN_CLEAR) begin
			wr_en   = s1_adv;
			wr_data = word & s1_pat;
		end else if (s1_func == FN_WAIT) begin
			if (s1_pat == '0 || (s1_mode != MODE_ALL && s1_mode != MODE_ANY)) begin
				status = ST_BAD_PAR;
			end else if (met) begin
				seen  = word;
				wr_en = s1_adv && auto_clr;
			end else begin
				status = ST_NOT_MET;
			end
		end else begin
			status = ST_BAD_PAR;
		end
	end

	assign seen_wide = MAX_WORD_W'(seen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			valid_q     <= '0;
		end else if (wr_en) begin
			fwd_valid_q      <= 1'b1;
			valid_q[s1_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= s1_addr;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_status_q <= status;
			res_pat_q    <= seen_wide[PAT_W-1:0];
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.flag_pattern = res_pat_q;

endmodule

// File: rtl/core/eft_checker.sv
// Port-level checks for the event flag table, bound to the top level.
module eft_checker import eft_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                op_valid,
	input logic                op_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic [STATUS_W-1:0] res_status,
	input logic [PAT_W-1:0]    res_flag_pattern
);

	logic [1:0] inflight_q;
	logic       op_xfer;
	logic       res_xfer;

	assign op_xfer  = op_valid && op_ready;
	assign res_xfer = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (op_xfer && !res_xfer) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (res_xfer && !op_xfer) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_flag_pattern))
		else $error("result dropped or changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 2'd0)
		else $error("result without a pending op");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more than two ops in flight");

	a_pat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_flag_pattern != '0 |-> res_status == ST_OK)
		else $error("flag word returned with an error status");

endmodule

bind event_flag_table eft_checker u_eft_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.op_valid         (op.valid),
	.op_ready         (op.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_flag_pattern (res.flag_pattern)
);
